// ===== hw/rtl/qte_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle block.
package qte_pkg;

  // Component format: signed, CompWidth bits, CompWidth-2 fraction bits
  localparam int CompWidth   = 16;
  localparam int AngleWidth  = 16;
  // Component product in Q30, magnitude up to 2^32
  localparam int ProdW       = 34;
  // Sums and 1-2(...) terms in Q30, magnitude up to 2^34
  localparam int ValW        = 36;
  // Clamped asin argument, range [-2^30, 2^30]
  localparam int SinW        = 32;
  // Square root of up to 2^60
  localparam int RootW       = 31;
  localparam int RemW        = 62;
  // Angle accumulator, 2^32 is one full turn
  localparam int ZW          = 34;
  localparam int AngleTabLen = 24;

  // Scaling of a raw product into Q30
  localparam int ProdFrac = 2 * (CompWidth - 2);
  localparam int ProdShR  = (ProdFrac > 30) ? ProdFrac - 30 : 0;
  localparam int ProdShL  = (ProdFrac > 30) ? 0 : 30 - ProdFrac;

  localparam logic signed [ValW-1:0] Q30One      = ValW'(64'd1 << 30);
  localparam logic signed [ZW-1:0]   QuarterTurn = ZW'(64'd1 << 30);

  // atan(2^-i) with 2^32 per turn
  localparam logic [31:0] AngleStep [0:AngleTabLen-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [CompWidth-1:0] q_w;
    logic signed [CompWidth-1:0] q_x;
    logic signed [CompWidth-1:0] q_y;
    logic signed [CompWidth-1:0] q_z;
  } qte_quat_t;

  typedef struct packed {
    logic signed [AngleWidth-1:0] roll_angle;
    logic signed [AngleWidth-1:0] pitch_angle;
    logic signed [AngleWidth-1:0] yaw_angle;
    logic                         pitch_clamped;
  } qte_euler_t;

  // Classified work item between front and back
  typedef struct packed {
    logic signed [ValW-1:0] roll_y;
    logic signed [ValW-1:0] roll_x;
    logic signed [ValW-1:0] yaw_y;
    logic signed [ValW-1:0] yaw_x;
    logic signed [SinW-1:0] sin_arg;
    logic                   clamp;
  } qte_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qte_fifo_st_t;

endpackage

// ===== hw/rtl/qte_front.sv =====
// Front end: component products, atan2 operands and asin argument clamp.
module qte_front import qte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  qte_quat_t quat_i,
  output logic      push_o,
  output qte_cmd_t  cmd_o
);

  function automatic logic signed [ProdW-1:0] mul_q30(
    input logic signed [CompWidth-1:0] a,
    input logic signed [CompWidth-1:0] b
  );
    logic signed [2*CompWidth-1:0] p;
    logic signed [63:0]            e;
    p = a * b;
    e = 64'(p);
    e = (e >>> ProdShR) <<< ProdShL;
    return ProdW'(e);
  endfunction

  logic signed [ProdW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, xz_q, wz_q, xy_q, zz_q;
  logic                    v1_q, v2_q;
  qte_cmd_t                cmd_q, cmd_d;

  // Stage 1: products in Q30
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      wx_q <= mul_q30(quat_i.q_w, quat_i.q_x);
      yz_q <= mul_q30(quat_i.q_y, quat_i.q_z);
      xx_q <= mul_q30(quat_i.q_x, quat_i.q_x);
      yy_q <= mul_q30(quat_i.q_y, quat_i.q_y);
      wy_q <= mul_q30(quat_i.q_w, quat_i.q_y);
      xz_q <= mul_q30(quat_i.q_x, quat_i.q_z);
      wz_q <= mul_q30(quat_i.q_w, quat_i.q_z);
      xy_q <= mul_q30(quat_i.q_x, quat_i.q_y);
      zz_q <= mul_q30(quat_i.q_z, quat_i.q_z);
    end
  end

  // Stage 2: sums, 1-2(...) terms and clamp of the asin argument
  always_comb begin
    logic signed [ValW-1:0] s_raw;
    cmd_d.roll_y = (ValW'(wx_q) + ValW'(yz_q)) <<< 1;
    cmd_d.roll_x = Q30One - ((ValW'(xx_q) + ValW'(yy_q)) <<< 1);
    cmd_d.yaw_y  = (ValW'(wz_q) + ValW'(xy_q)) <<< 1;
    cmd_d.yaw_x  = Q30One - ((ValW'(yy_q) + ValW'(zz_q)) <<< 1);
    s_raw        = (ValW'(wy_q) - ValW'(xz_q)) <<< 1;
    priority if (s_raw > Q30One) begin
      cmd_d.sin_arg = SinW'(Q30One);
      cmd_d.clamp   = 1'b1;
    end else if (s_raw < -Q30One) begin
      cmd_d.sin_arg = SinW'(-Q30One);
      cmd_d.clamp   = 1'b1;
    end else begin
      cmd_d.sin_arg = SinW'(s_raw);
      cmd_d.clamp   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      cmd_q <= cmd_d;
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
    end
  end

  assign push_o = v2_q;
  assign cmd_o  = cmd_q;

endmodule

// ===== hw/rtl/qte_fifo.sv =====
// Small register queue between the front and back ends.
module qte_fifo import qte_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  qte_cmd_t     data_i,
  input  logic         pop_i,
  output qte_cmd_t     data_o,
  output qte_fifo_st_t status_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  qte_cmd_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign do_push = push_i && ((cnt_q != CntW'(Depth)) || do_pop);

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  assign data_o         = mem_q[rd_q];
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(Depth));

endmodule

// ===== hw/rtl/qte_isqrt.sv =====
// Pipelined cosine term: floor(sqrt(2^60 - s^2)), one root bit per stage.
module qte_isqrt import qte_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [SinW-1:0] sin_i,
  input  logic [SideW-1:0]       side_i,
  output logic                   valid_o,
  output logic [RootW-1:0]       root_o,
  output logic [SideW-1:0]       side_o
);

  logic [SinW-1:0]  mag;
  logic [29:0]      hh_q;
  logic [30:0]      hl_q;
  logic [31:0]      ll_q;
  logic             va_q;
  logic [SideW-1:0] sa_q;

  logic [RemW-1:0]  rem_q  [0:RootW];
  logic [RootW-1:0] root_q [0:RootW];
  logic [SideW-1:0] side_q [0:RootW];
  logic             vld_q  [0:RootW];

  // Stage A: split |s| and form partial squares
  assign mag = sin_i[SinW-1] ? SinW'(-sin_i) : SinW'(sin_i);

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      hh_q <= 30'(mag[30:16] * mag[30:16]);
      hl_q <= 31'(mag[30:16] * mag[15:0]);
      ll_q <= 32'(mag[15:0] * mag[15:0]);
      sa_q <= side_i;
    end
  end

  // Stage B: radicand
  always_ff @(posedge clk_i) begin
    if (va_q) begin
      rem_q[0]  <= (RemW'(1) << 60)
                 - ((RemW'(hh_q) << 32) + (RemW'(hl_q) << 17) + RemW'(ll_q));
      root_q[0] <= '0;
      side_q[0] <= sa_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      vld_q[0] <= 1'b0;
    end else begin
      va_q     <= valid_i;
      vld_q[0] <= va_q;
    end
  end

  // Digit stages, most significant root bit first
  for (genvar j = 1; j <= RootW; j++) begin : g_digit
    localparam int K = RootW - j;
    logic [RemW-1:0] trial;
    logic            fits;

    assign trial = (RemW'(root_q[j-1]) << (K + 1)) + (RemW'(1) << (2 * K));
    assign fits  = (rem_q[j-1] >= trial);

    always_ff @(posedge clk_i) begin
      if (vld_q[j-1]) begin
        rem_q[j]  <= fits ? rem_q[j-1] - trial : rem_q[j-1];
        root_q[j] <= fits ? (root_q[j-1] | (RootW'(1) << K)) : root_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = root_q[RootW];
  assign side_o  = side_q[RootW];

endmodule

// ===== hw/rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC atan2, rounded to 16-bit binary angle.
module qte_cordic import qte_pkg::*; #(
  parameter int Stages = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [ValW-1:0]       y_i,
  input  logic signed [ValW-1:0]       x_i,
  output logic                         valid_o,
  output logic signed [AngleWidth-1:0] angle_o
);

  localparam int XW = ValW + 2;

  logic signed [XW-1:0] x_q [0:Stages];
  logic signed [XW-1:0] y_q [0:Stages];
  logic signed [ZW-1:0] z_q [0:Stages];
  logic                 zf_q [0:Stages];
  logic                 v_q  [0:Stages];

  logic signed [XW-1:0] xe, ye, x0, y0;
  logic signed [ZW-1:0] z0;
  logic signed [ZW-1:0] zr;
  logic signed [AngleWidth-1:0] angle_q;
  logic                 vo_q;

  // Quadrant fold for a negative x
  assign xe = XW'(x_i);
  assign ye = XW'(y_i);

  always_comb begin
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe[XW-1]) begin
      if (!ye[XW-1]) begin
        x0 = ye;
        y0 = -xe;
        z0 = QuarterTurn;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -QuarterTurn;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      x_q[0]  <= x0;
      y_q[0]  <= y0;
      z_q[0]  <= z0;
      zf_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  // Micro-rotations
  for (genvar i = 0; i < Stages; i++) begin : g_rot
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] step;

    assign dx   = y_q[i] >>> i;
    assign dy   = x_q[i] >>> i;
    assign step = ZW'(AngleStep[i]);

    always_ff @(posedge clk_i) begin
      if (v_q[i]) begin
        if (!y_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + step;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - step;
        end
        zf_q[i+1] <= zf_q[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end
  end

  // Round half up to binary angle; both operands zero gives zero
  assign zr = z_q[Stages] + ZW'(32768);

  always_ff @(posedge clk_i) begin
    if (v_q[Stages]) begin
      angle_q <= zf_q[Stages] ? '0 : zr[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[Stages];
    end
  end

  assign valid_o = vo_q;
  assign angle_o = angle_q;

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// Top level: quaternion to roll, pitch and yaw in binary angle units.
//
// Input channel: quat_i (w, x, y, z, signed Q1.14) is transferred at a
// rising edge with start_i high and busy_o low. A new quaternion may be
// started every cycle while busy_o is low.
// Output channel: valid_o is high for exactly one cycle with euler_o
// holding roll, negated pitch, negated yaw (32768 = pi) and the flag that
// the asin argument was saturated. Results leave in input order.
// Pipeline: CORDIC_STAGES + 40 register stages from transfer to result
// transfer (2 front stages, 1 queue stage, 1 issue register, 33 square
// root stages, CORDIC_STAGES + 2 CORDIC stages, 1 output register).
// Throughput: one quaternion per cycle. The back end drains the queue
// every cycle, so busy_o stays low in operation.
// Reset: rst_ni clears all valid flags and the queue; items in flight are
// dropped. The receiver cannot stall: results are shown once and must be
// taken in that cycle.
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  qte_quat_t  quat_i,
  output logic       valid_o,
  output qte_euler_t euler_o
);

  localparam int CordicLat = CORDIC_STAGES + 2;

  logic         accept;
  logic         push;
  qte_cmd_t     push_cmd;
  qte_cmd_t     head_cmd;
  qte_fifo_st_t fifo_st;
  logic         issue_q;
  qte_cmd_t     issue_cmd_q;

  logic             sq_vld;
  logic [RootW-1:0] sq_root;
  qte_cmd_t         sq_cmd;

  logic                         roll_vld, pitch_vld, yaw_vld;
  logic signed [AngleWidth-1:0] roll_ang, pitch_ang, yaw_ang;
  logic                         clamp_q [0:CordicLat-1];

  qte_euler_t euler_q;
  logic       valid_q;

  assign accept = start_i && !busy_o;
  assign busy_o = fifo_st.full;

  qte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .quat_i   (quat_i),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  qte_fifo #(
    .Depth (2)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_cmd),
    .pop_i    (!fifo_st.empty),
    .data_o   (head_cmd),
    .status_o (fifo_st)
  );

  // Issue register: back end takes the queue head every cycle it is not empty
  always_ff @(posedge clk_i) begin
    if (!fifo_st.empty) begin
      issue_cmd_q <= head_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
    end else begin
      issue_q <= !fifo_st.empty;
    end
  end

  qte_isqrt #(
    .SideW ($bits(qte_cmd_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (issue_q),
    .sin_i   (issue_cmd_q.sin_arg),
    .side_i  (issue_cmd_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_cmd)
  );

  qte_cordic #(
    .Stages (CORDIC_STAGES)
  ) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .y_i     (sq_cmd.roll_y),
    .x_i     (sq_cmd.roll_x),
    .valid_o (roll_vld),
    .angle_o (roll_ang)
  );

  qte_cordic #(
    .Stages (CORDIC_STAGES)
  ) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .y_i     (ValW'(sq_cmd.sin_arg)),
    .x_i     (ValW'(sq_root)),
    .valid_o (pitch_vld),
    .angle_o (pitch_ang)
  );

  qte_cordic #(
    .Stages (CORDIC_STAGES)
  ) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .y_i     (sq_cmd.yaw_y),
    .x_i     (sq_cmd.yaw_x),
    .valid_o (yaw_vld),
    .angle_o (yaw_ang)
  );

  // Clamp flag rides alongside the CORDIC pipelines
  always_ff @(posedge clk_i) begin
    clamp_q[0] <= sq_cmd.clamp;
    for (int i = 1; i < CordicLat; i++) begin
      clamp_q[i] <= clamp_q[i-1];
    end
  end

  // Output register with pitch and yaw negation
  always_ff @(posedge clk_i) begin
    if (pitch_vld) begin
      euler_q.roll_angle    <= roll_ang;
      euler_q.pitch_angle   <= AngleWidth'(-pitch_ang);
      euler_q.yaw_angle     <= AngleWidth'(-yaw_ang);
      euler_q.pitch_clamped <= clamp_q[CordicLat-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= pitch_vld;
    end
  end

  assign valid_o = valid_q;
  assign euler_o = euler_q;

`ifndef SYNTHESIS
  // The three angle pipelines stay in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (roll_vld == pitch_vld) && (yaw_vld == pitch_vld))
    else $error("angle pipelines out of step");

  // The back end drains every cycle, so the queue never fills
  assert property (@(posedge clk_i) disable iff (!rst_ni) !fifo_st.full)
    else $error("work queue filled up");

  // A queued item is issued to the back end in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_st.empty |=> issue_q)
    else $error("queued item not issued");
`endif

endmodule
